FILE: rtl/ssi_master_double_read_verify_defines.svh
// ---------------------------------------------------------------------------
// SSI master double read verify: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SSI_MASTER_DOUBLE_READ_VERIFY_DEFINES_SVH
`define SSI_MASTER_DOUBLE_READ_VERIFY_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define SSIM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ssimdrv_pkg.sv
// ---------------------------------------------------------------------------
// SSI master double read verify package
// Sequencer phase codes, register indices, reset values and fixed widths.
// ---------------------------------------------------------------------------
package ssimdrv_pkg;

  localparam int MAX_WORD_BITS = 32;
  localparam int WORD_W        = 32;
  localparam int TICK_W        = 16;
  localparam int BITIDX_W      = 6;
  localparam int TRY_W         = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [WORD_W-1:0] FAIL_WORD = 32'h0000_FFFF;

  localparam logic [BITIDX_W-1:0] WORD_SIZE_RST  = 6'd24;
  localparam logic [TICK_W-1:0]   HALF_TICKS_RST = 16'd10;
  localparam logic [TICK_W-1:0]   GAP_TICKS_RST  = 16'd20;
  localparam logic [TRY_W-1:0]    MAX_TRIES_RST  = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD_SIZE  = 2'd0,
    REG_HALF_TICKS = 2'd1,
    REG_GAP_TICKS  = 2'd2,
    REG_MAX_TRIES  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

endpackage

FILE: rtl/ssi_master_double_read_verify.sv
// ---------------------------------------------------------------------------
// SSI master double read verify
// Clocks a position word out of an SSI sensor twice and checks the readings.
// ---------------------------------------------------------------------------
// Each input item is one time tick and yields exactly one result item. A
// tick is taken every clock cycle; its result appears in the output register
// on the next cycle, and a new tick is taken while that result waits unless
// the output register is stalled and full. The sequencer state and the one
// result register are the only storage. A sequence starts on a tick with
// start_req in idle; each bit is half_period_ticks clock-low ticks then
// as many clock-high ticks, the data line is sampled on the last high tick,
// and the word is read MSB first, a gap of gap_ticks clock-high ticks apart
// from its repeat. Matching reads finish with the word; after max_tries
// mismatching attempts the block finishes with 65535 and read_failed set.
`include "ssi_master_double_read_verify_defines.svh"

module ssi_master_double_read_verify (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [ssimdrv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssimdrv_pkg::CFG_DATA_W-1:0]   cfg_data,
  // tick input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 start_req,
  input  logic                                 data_in,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 clock_out,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic [ssimdrv_pkg::WORD_W-1:0]       position,
  output logic                                 read_failed
);

  // configuration registers
  logic [ssimdrv_pkg::BITIDX_W-1:0] word_size;
  logic [ssimdrv_pkg::TICK_W-1:0]   half_period_ticks;
  logic [ssimdrv_pkg::TICK_W-1:0]   gap_ticks;
  logic [ssimdrv_pkg::TRY_W-1:0]    max_tries;

  // sequencer state
  ssimdrv_pkg::phase_t              phase, phase_next;
  logic [ssimdrv_pkg::TICK_W-1:0]   tick_count, tick_count_next;
  logic [ssimdrv_pkg::BITIDX_W-1:0] bit_index, bit_index_next;
  logic [ssimdrv_pkg::WORD_W-1:0]   first_word, first_word_next;
  logic [ssimdrv_pkg::WORD_W-1:0]   second_word, second_word_next;
  logic                             second_pass, second_pass_next;
  logic [ssimdrv_pkg::TRY_W-1:0]    try_count, try_count_next;

  // result of the current tick
  logic                             clk_r, busy_r, done_r, failed_r;
  logic [ssimdrv_pkg::WORD_W-1:0]   pos_r;

  logic                             in_accept;
  logic [ssimdrv_pkg::TICK_W-1:0]   hp_eff, gap_eff;
  logic [ssimdrv_pkg::BITIDX_W-1:0] word_bits;
  logic [ssimdrv_pkg::TRY_W-1:0]    tries_eff;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign hp_eff    = (half_period_ticks == '0) ? ssimdrv_pkg::TICK_W'(1) : half_period_ticks;
  assign gap_eff   = (gap_ticks == '0) ? ssimdrv_pkg::TICK_W'(1) : gap_ticks;
  assign tries_eff = (max_tries == '0) ? ssimdrv_pkg::TRY_W'(1) : max_tries;

  always_comb begin
    if (word_size == '0) begin
      word_bits = ssimdrv_pkg::BITIDX_W'(1);
    end else if (word_size > ssimdrv_pkg::BITIDX_W'(ssimdrv_pkg::MAX_WORD_BITS)) begin
      word_bits = ssimdrv_pkg::BITIDX_W'(ssimdrv_pkg::MAX_WORD_BITS);
    end else begin
      word_bits = word_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_size         <= ssimdrv_pkg::WORD_SIZE_RST;
      half_period_ticks <= ssimdrv_pkg::HALF_TICKS_RST;
      gap_ticks         <= ssimdrv_pkg::GAP_TICKS_RST;
      max_tries         <= ssimdrv_pkg::MAX_TRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssimdrv_pkg::REG_WORD_SIZE:  word_size         <= cfg_data[ssimdrv_pkg::BITIDX_W-1:0];
        ssimdrv_pkg::REG_HALF_TICKS: half_period_ticks <= cfg_data;
        ssimdrv_pkg::REG_GAP_TICKS:  gap_ticks         <= cfg_data;
        ssimdrv_pkg::REG_MAX_TRIES:  max_tries         <= cfg_data[ssimdrv_pkg::TRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    first_word_next  = first_word;
    second_word_next = second_word;
    second_pass_next = second_pass;
    try_count_next   = try_count;
    clk_r            = 1'b1;
    busy_r           = 1'b0;
    done_r           = 1'b0;
    failed_r         = 1'b0;
    pos_r            = '0;

    // start tick is already the first clock-low tick
    if (phase == ssimdrv_pkg::PH_IDLE && start_req) begin
      phase_next       = ssimdrv_pkg::PH_LOW;
      tick_count_next  = '0;
      bit_index_next   = '0;
      first_word_next  = '0;
      second_word_next = '0;
      second_pass_next = 1'b0;
      try_count_next   = '0;
    end

    if (phase_next != ssimdrv_pkg::PH_IDLE) begin
      busy_r          = 1'b1;
      clk_r           = (phase_next != ssimdrv_pkg::PH_LOW);
      tick_count_next = tick_count_next + ssimdrv_pkg::TICK_W'(1);

      case (phase_next)
        ssimdrv_pkg::PH_LOW: begin
          if (tick_count_next >= hp_eff) begin
            phase_next      = ssimdrv_pkg::PH_HIGH;
            tick_count_next = '0;
          end
        end
        ssimdrv_pkg::PH_GAP: begin
          if (tick_count_next >= gap_eff) begin
            phase_next       = ssimdrv_pkg::PH_LOW;
            tick_count_next  = '0;
            bit_index_next   = '0;
            second_pass_next = 1'b1;
          end
        end
        ssimdrv_pkg::PH_HIGH: begin
          // sample at the end of the high phase
          if (tick_count_next >= hp_eff) begin
            tick_count_next = '0;
            if (second_pass_next) begin
              second_word_next = {second_word_next[ssimdrv_pkg::WORD_W-2:0], data_in};
            end else begin
              first_word_next = {first_word_next[ssimdrv_pkg::WORD_W-2:0], data_in};
            end
            bit_index_next = bit_index_next + ssimdrv_pkg::BITIDX_W'(1);
            if (bit_index_next < word_bits) begin
              phase_next = ssimdrv_pkg::PH_LOW;
            end else if (!second_pass_next) begin
              phase_next = ssimdrv_pkg::PH_GAP;
            end else if (first_word_next == second_word_next) begin
              done_r     = 1'b1;
              pos_r      = first_word_next;
              phase_next = ssimdrv_pkg::PH_IDLE;
            end else begin
              try_count_next = try_count_next + ssimdrv_pkg::TRY_W'(1);
              if (try_count_next >= tries_eff) begin
                done_r           = 1'b1;
                failed_r         = 1'b1;
                pos_r            = ssimdrv_pkg::FAIL_WORD;
                phase_next       = ssimdrv_pkg::PH_IDLE;
                first_word_next  = '0;
                second_word_next = '0;
              end else begin
                // retry the double read
                phase_next       = ssimdrv_pkg::PH_LOW;
                tick_count_next  = '0;
                bit_index_next   = '0;
                first_word_next  = '0;
                second_word_next = '0;
                second_pass_next = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ssimdrv_pkg::PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      first_word  <= '0;
      second_word <= '0;
      second_pass <= 1'b0;
      try_count   <= '0;
    end else if (in_accept) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      first_word  <= first_word_next;
      second_word <= second_word_next;
      second_pass <= second_pass_next;
      try_count   <= try_count_next;
    end
  end

  // output register: load on accept, hold while stalled, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      clock_out   <= clk_r;
      busy_res    <= busy_r;
      done_res    <= done_r;
      position    <= pos_r;
      read_failed <= failed_r;
    end
  end

  `SSIM_ASSERT_SAME(a_fail_word, out_valid && read_failed,
                    done_res && busy_res && position == ssimdrv_pkg::FAIL_WORD,
                    "failure result without done or fail word")
  `SSIM_ASSERT_NEXT(a_busy_seq, in_accept && phase != ssimdrv_pkg::PH_IDLE,
                    out_valid && busy_res, "tick inside a sequence not reported busy")
  `SSIM_ASSERT_NEXT(a_done_idle, in_accept, !done_res || phase == ssimdrv_pkg::PH_IDLE,
                    "sequence finished but sequencer not idle")
  `SSIM_ASSERT_SAME(a_low_busy, out_valid && !clock_out, busy_res,
                    "clock driven low outside a sequence")

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSI double-read master testbench
// Drives time ticks into the SSI master while a simple sensor model answers
// on the data line, predicts every result tick in a scoreboard class and
// compares each one field by field. Covers directed corner configurations,
// forced mismatches and retries, then randomized reads with random idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int TICK_GOAL   = 650;

  typedef struct {
    logic                           clk_lvl;
    logic                           busy;
    logic                           done;
    logic [ssimdrv_pkg::WORD_W-1:0] pos;
    logic                           failed;
  } ssi_result_t;

  class ssi_scoreboard;
    logic [ssimdrv_pkg::BITIDX_W-1:0] word_size;
    logic [ssimdrv_pkg::TICK_W-1:0]   half_ticks;
    logic [ssimdrv_pkg::TICK_W-1:0]   gap_ticks;
    logic [ssimdrv_pkg::TRY_W-1:0]    max_tries;

    ssimdrv_pkg::phase_t              phase;
    logic [ssimdrv_pkg::TICK_W-1:0]   tick_count;
    logic [ssimdrv_pkg::BITIDX_W-1:0] bit_index;
    logic [ssimdrv_pkg::WORD_W-1:0]   first_word;
    logic [ssimdrv_pkg::WORD_W-1:0]   second_word;
    logic                             second_pass;
    logic [ssimdrv_pkg::TRY_W-1:0]    try_count;

    ssi_result_t         tick_results[$];
    int unsigned         errors;
    int unsigned         ticks_seen;
    int unsigned         results_checked;
    int unsigned         seq_done;
    int unsigned         reads_failed;

    function new();
      word_size   = ssimdrv_pkg::WORD_SIZE_RST;
      half_ticks  = ssimdrv_pkg::HALF_TICKS_RST;
      gap_ticks   = ssimdrv_pkg::GAP_TICKS_RST;
      max_tries   = ssimdrv_pkg::MAX_TRIES_RST;
      phase       = ssimdrv_pkg::PH_IDLE;
      tick_count  = '0;
      bit_index   = '0;
      first_word  = '0;
      second_word = '0;
      second_pass = 1'b0;
      try_count   = '0;
      errors      = 0;
      ticks_seen  = 0;
      results_checked = 0;
      seq_done    = 0;
      reads_failed = 0;
    endfunction

    function void write_reg(ssimdrv_pkg::cfg_reg_t idx,
                            logic [ssimdrv_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        ssimdrv_pkg::REG_WORD_SIZE:  word_size  = val[ssimdrv_pkg::BITIDX_W-1:0];
        ssimdrv_pkg::REG_HALF_TICKS: half_ticks = val[ssimdrv_pkg::TICK_W-1:0];
        ssimdrv_pkg::REG_GAP_TICKS:  gap_ticks  = val[ssimdrv_pkg::TICK_W-1:0];
        ssimdrv_pkg::REG_MAX_TRIES:  max_tries  = val[ssimdrv_pkg::TRY_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned word_len();
      int unsigned n;
      n = (word_size == '0) ? 32'd1 : {26'd0, word_size};
      if (n > ssimdrv_pkg::MAX_WORD_BITS) n = ssimdrv_pkg::MAX_WORD_BITS;
      return n;
    endfunction

    function logic [ssimdrv_pkg::TICK_W-1:0] half_len();
      return (half_ticks == 0) ? 16'd1 : half_ticks;
    endfunction

    // True when the next tick is the last high tick of a bit
    function bit sample_due();
      return (phase == ssimdrv_pkg::PH_HIGH) &&
             ({1'b0, tick_count} + 17'd1 >= {1'b0, half_len()});
    endfunction

    function void restart_try();
      phase       = ssimdrv_pkg::PH_LOW;
      tick_count  = '0;
      bit_index   = '0;
      first_word  = '0;
      second_word = '0;
      second_pass = 1'b0;
    endfunction

    function void note_tick(logic start, logic data);
      ssi_result_t                    r;
      logic [ssimdrv_pkg::TICK_W-1:0] hp;
      logic [ssimdrv_pkg::TICK_W-1:0] gp;
      logic [ssimdrv_pkg::TRY_W-1:0]  mt;
      hp = half_len();
      gp = (gap_ticks == 0) ? 16'd1 : gap_ticks;
      mt = (max_tries == 0) ? 3'd1 : max_tries;
      r.clk_lvl = 1'b1;
      r.busy    = 1'b0;
      r.done    = 1'b0;
      r.pos     = '0;
      r.failed  = 1'b0;
      ticks_seen++;
      if (phase == ssimdrv_pkg::PH_IDLE && start) begin
        restart_try();
        try_count = '0;
      end
      if (phase != ssimdrv_pkg::PH_IDLE) begin
        r.busy    = 1'b1;
        r.clk_lvl = (phase == ssimdrv_pkg::PH_LOW) ? 1'b0 : 1'b1;
        tick_count = tick_count + 16'd1;
        case (phase)
          ssimdrv_pkg::PH_LOW: begin
            if (tick_count >= hp) begin
              phase      = ssimdrv_pkg::PH_HIGH;
              tick_count = '0;
            end
          end
          ssimdrv_pkg::PH_GAP: begin
            if (tick_count >= gp) begin
              phase       = ssimdrv_pkg::PH_LOW;
              tick_count  = '0;
              bit_index   = '0;
              second_pass = 1'b1;
            end
          end
          default: begin
            if (tick_count >= hp) begin
              tick_count = '0;
              if (second_pass) second_word = {second_word[ssimdrv_pkg::WORD_W-2:0], data};
              else first_word = {first_word[ssimdrv_pkg::WORD_W-2:0], data};
              bit_index = bit_index + 6'd1;
              if (bit_index < word_len()) begin
                phase = ssimdrv_pkg::PH_LOW;
              end else if (!second_pass) begin
                phase = ssimdrv_pkg::PH_GAP;
              end else if (first_word == second_word) begin
                r.done = 1'b1;
                r.pos  = first_word;
                phase  = ssimdrv_pkg::PH_IDLE;
              end else begin
                try_count = try_count + 3'd1;
                if (try_count >= mt) begin
                  r.done      = 1'b1;
                  r.failed    = 1'b1;
                  r.pos       = ssimdrv_pkg::FAIL_WORD;
                  phase       = ssimdrv_pkg::PH_IDLE;
                  first_word  = '0;
                  second_word = '0;
                end else begin
                  restart_try();
                end
              end
            end
          end
        endcase
      end
      if (r.done) seq_done++;
      if (r.failed) reads_failed++;
      tick_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [ssimdrv_pkg::WORD_W-1:0] got,
                         logic [ssimdrv_pkg::WORD_W-1:0] want);
      errors++;
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_tick_result(ssi_result_t got);
      ssi_result_t want;
      if (tick_results.size() == 0) begin
        report_mismatch("result with no tick pending", '0, '0);
        return;
      end
      want = tick_results.pop_front();
      results_checked++;
      if (got.clk_lvl !== want.clk_lvl)
        report_mismatch("clock_out", ssimdrv_pkg::WORD_W'(got.clk_lvl),
                        ssimdrv_pkg::WORD_W'(want.clk_lvl));
      if (got.busy !== want.busy)
        report_mismatch("busy_res", ssimdrv_pkg::WORD_W'(got.busy),
                        ssimdrv_pkg::WORD_W'(want.busy));
      if (got.done !== want.done)
        report_mismatch("done_res", ssimdrv_pkg::WORD_W'(got.done),
                        ssimdrv_pkg::WORD_W'(want.done));
      if (got.pos !== want.pos) report_mismatch("position", got.pos, want.pos);
      if (got.failed !== want.failed)
        report_mismatch("read_failed", ssimdrv_pkg::WORD_W'(got.failed),
                        ssimdrv_pkg::WORD_W'(want.failed));
    endtask
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [ssimdrv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssimdrv_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               start_req = 1'b0;
  logic                               data_in = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               clock_out;
  logic                               busy_res;
  logic                               done_res;
  logic [ssimdrv_pkg::WORD_W-1:0]     position;
  logic                               read_failed;

  ssi_scoreboard sb = new();

  int          cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;
  int unsigned stall_run = 0;
  int unsigned cfg_phases = 0;

  // Sensor model knobs
  int unsigned                    start_pct = 100;
  int unsigned                    busy_start_pct = 10;
  int unsigned                    err_pct = 0;
  int unsigned                    corrupt_tries = 0;
  bit                             use_forced = 1'b0;
  logic [ssimdrv_pkg::WORD_W-1:0] forced_word = '0;
  logic [ssimdrv_pkg::WORD_W-1:0] sensor_word = '0;

  ssi_master_double_read_verify dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_req   (start_req),
    .data_in     (data_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .clock_out   (clock_out),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .position    (position),
    .read_failed (read_failed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check accepted items, then pick the next stall level
  always @(posedge clk) begin
    ssi_result_t got;
    logic        stall_nxt;
    if (!rst && out_valid && !out_stall) begin
      got.clk_lvl = clock_out;
      got.busy    = busy_res;
      got.done    = done_res;
      got.pos     = position;
      got.failed  = read_failed;
      sb.check_tick_result(got);
    end
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(32, 200);
    end
    stall_mode_left--;
    stall_nxt = 1'b0;
    case (stall_mode)
      1: stall_nxt = ($urandom_range(0, 3) == 0);
      2: begin
        if (stall_run == 0 && $urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 8);
        if (stall_run != 0) begin
          stall_nxt = 1'b1;
          stall_run--;
        end
      end
      3: stall_nxt = (cycles % 3 == 0);
      default: stall_nxt = 1'b0;
    endcase
    out_stall <= stall_nxt;
  end

  task automatic send_tick(logic s, logic d);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= s;
    data_in   <= d;
    do @(posedge clk); while (in_stall);
    sb.note_tick(s, d);
  endtask

  // Choose start and data for the next tick from the sensor model
  task automatic next_tick();
    logic        s;
    logic        d;
    int unsigned bpos;
    if (sb.phase == ssimdrv_pkg::PH_IDLE) s = ($urandom_range(0, 99) < start_pct);
    else s = ($urandom_range(0, 99) < busy_start_pct);
    if (sb.phase == ssimdrv_pkg::PH_IDLE && s) begin
      if (use_forced) begin
        sensor_word = forced_word;
      end else begin
        case ($urandom_range(0, 7))
          0: sensor_word = '0;
          1: sensor_word = '1;
          2: sensor_word = ssimdrv_pkg::FAIL_WORD;
          default: sensor_word = $urandom;
        endcase
      end
    end
    d = 1'($urandom_range(0, 1));
    if (sb.sample_due()) begin
      bpos = sb.word_len() - 1 - {26'd0, sb.bit_index};
      d = sensor_word[bpos];
      if (sb.second_pass && sb.try_count < corrupt_tries) d = ~d;
      if ($urandom_range(0, 99) < err_pct) d = ~d;
    end
    send_tick(s, d);
  endtask

  task automatic run_reads(int unsigned n);
    int unsigned target;
    target = sb.seq_done + n;
    while (sb.seq_done < target) next_tick();
  endtask

  task automatic directed_read(logic [ssimdrv_pkg::WORD_W-1:0] word, int unsigned bad_tries);
    use_forced    = 1'b1;
    forced_word   = word;
    corrupt_tries = bad_tries;
    run_reads(1);
    use_forced    = 1'b0;
    corrupt_tries = 0;
  endtask

  // Hold the sender until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.tick_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Finish the running sequence, then drain
  task automatic settle();
    while (sb.phase != ssimdrv_pkg::PH_IDLE) next_tick();
    drain();
  endtask

  task automatic write_cfg(ssimdrv_pkg::cfg_reg_t idx,
                           logic [ssimdrv_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(logic [ssimdrv_pkg::CFG_DATA_W-1:0] bc,
                              logic [ssimdrv_pkg::CFG_DATA_W-1:0] hp,
                              logic [ssimdrv_pkg::CFG_DATA_W-1:0] gp,
                              logic [ssimdrv_pkg::CFG_DATA_W-1:0] mt);
    settle();
    write_cfg(ssimdrv_pkg::REG_WORD_SIZE, bc);
    write_cfg(ssimdrv_pkg::REG_HALF_TICKS, hp);
    write_cfg(ssimdrv_pkg::REG_GAP_TICKS, gp);
    write_cfg(ssimdrv_pkg::REG_MAX_TRIES, mt);
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  initial begin
    logic [ssimdrv_pkg::CFG_DATA_W-1:0] bc;
    logic [ssimdrv_pkg::CFG_DATA_W-1:0] hp;
    logic [ssimdrv_pkg::CFG_DATA_W-1:0] gp;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset timing: watch the first bit of a read at the reset half period
    use_forced  = 1'b1;
    forced_word = 32'h00AB_CDEF;
    repeat (25) next_tick();
    drain();
    // Speed up the running read; word length and tries stay at reset
    write_cfg(ssimdrv_pkg::REG_HALF_TICKS, 16'd1);
    write_cfg(ssimdrv_pkg::REG_GAP_TICKS, 16'd1);
    cfg_we <= 1'b0;
    cfg_phases++;
    run_reads(1);
    use_forced = 1'b0;

    // Oversized word length saturates to the full word
    apply_config(16'd63, 16'd1, 16'd1, 16'd2);
    directed_read(32'h8000_0001, 0);

    // A genuine 0xFFFF word
    apply_config(16'd16, 16'd1, 16'd2, 16'd3);
    directed_read(32'h0000_FFFF, 0);

    // Recovery after retries, then exhausted retries
    apply_config(16'd4, 16'd1, 16'd2, 16'd3);
    directed_read(32'h0000_000A, 2);
    directed_read(32'h0000_0005, 7);

    // Masked word length, zero half period and gap, seven tries
    apply_config(16'hFFC2, 16'd0, 16'd0, 16'd7);
    directed_read(32'h0000_0003, 7);
    directed_read(32'h0000_0002, 0);

    // Zero word length and zero tries: one bit, one attempt
    apply_config(16'd0, 16'd1, 16'd2, 16'hFFF8);
    directed_read(32'h0000_0001, 7);
    directed_read(32'h0000_0001, 0);

    // Hold start high through whole sequences, finishing ticks included
    apply_config(16'd2, 16'd1, 16'd1, 16'd3);
    busy_start_pct = 100;
    run_reads(2);
    busy_start_pct = 10;

    // Random reads over random small configurations
    while (sb.ticks_seen < TICK_GOAL) begin
      case ($urandom_range(0, 9))
        0: bc = 16'd0;
        1: bc = 16'($urandom_range(6, 8));
        default: bc = 16'($urandom_range(1, 5));
      endcase
      if ($urandom_range(0, 3) == 0) bc = bc | (16'($urandom) & 16'hFFC0);
      hp = 16'($urandom_range(0, 2));
      gp = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(5, 12)) : 16'($urandom_range(0, 3));
      apply_config(bc, hp, gp, 16'($urandom_range(0, 7)));
      case ($urandom_range(0, 3))
        0: err_pct = 0;
        1: err_pct = 2;
        2: err_pct = 10;
        default: err_pct = 25;
      endcase
      corrupt_tries  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 7) : 0;
      start_pct      = $urandom_range(10, 100);
      busy_start_pct = $urandom_range(0, 50);
      run_reads($urandom_range(1, 3));
    end
    corrupt_tries = 0;
    err_pct = 0;

    in_valid <= 1'b0;
    while (sb.tick_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d result items over %0d ticks and %0d register settings",
             sb.results_checked, sb.ticks_seen, cfg_phases);
    $display("Completed %0d reads, %0d of them ending in read failure",
             sb.seq_done, sb.reads_failed);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
